>>> rtl/x86_unsigned_divide_core_assert.svh
// assertion macros for the unsigned divide core
`ifndef X86_UNSIGNED_DIVIDE_CORE_ASSERT_SVH
`define X86_UNSIGNED_DIVIDE_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define XUD_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define XUD_ASSERT_NXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> rtl/xud_pkg.sv
// ----------------------------------------------------------------------------
// xud_pkg
// types, constants and status codes shared by the divide core
// ----------------------------------------------------------------------------
package xud_pkg;
	localparam int unsigned StepsPerStage = 4;
	localparam int unsigned NumStages = 64 / StepsPerStage;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_WORD = 2'd1,
		SZ_DWORD = 2'd2,
		SZ_QWORD = 2'd3
	} opsize_t;

	// input item
	typedef struct packed {
		opsize_t     size_sel;
		logic [63:0] dividend_low;
		logic [63:0] dividend_high;
		logic [63:0] divisor;
	} div_req_t;

	// output item
	typedef struct packed {
		logic [63:0] quotient;
		logic [63:0] remainder;
		status_t     status;
	} div_rsp_t;

	typedef struct packed {
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		status_t     st;
	} work_t;
endpackage

>>> rtl/xud_stream_if.sv
// ----------------------------------------------------------------------------
// xud_stream_if
// valid/ready channel carrying a payload of parameterized type
// ----------------------------------------------------------------------------
interface xud_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/xud_div_stage.sv
// ----------------------------------------------------------------------------
// xud_div_stage
// four restoring divide steps on one item, combinational
// ----------------------------------------------------------------------------
module xud_div_stage (
	input  xud_pkg::work_t w_in,
	output xud_pkg::work_t w_out
);
	import xud_pkg::*;

	always_comb begin
		logic        top;
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] q;
		r = w_in.r;
		n = w_in.n;
		q = w_in.q;
		for (int i = 0; i < StepsPerStage; i++) begin
			top = r[63];
			r = {r[62:0], n[63]};
			n = {n[62:0], 1'b0};
			q = {q[62:0], 1'b0};
			if (top || r >= w_in.d) begin
				r = r - w_in.d;
				q[0] = 1'b1;
			end
		end
		w_out = w_in;
		w_out.r = r;
		w_out.n = n;
		w_out.q = q;
	end
endmodule

>>> rtl/x86_unsigned_divide_core.sv
// an accepted input item is registered in wrk_s[0], then in one register per divide stage up to wrk_s[NumStages]
// throughput: one item per cycle while the output is not stalled, set by sixteen stages of four divide steps
// a stall holds every stage; ready falls only when the output is held full
// arst_n clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// x86_unsigned_divide_core
// pipelined x86 DIV for byte, word, dword and qword operand sizes
// ----------------------------------------------------------------------------
module x86_unsigned_divide_core (
	input logic clk,
	input logic arst_n,
	xud_stream_if.sink   in_ch,
	xud_stream_if.source out_ch
);
	import xud_pkg::*;
	`include "x86_unsigned_divide_core_assert.svh"

	logic [NumStages:0] vld_s;
	work_t              wrk_s [NumStages+1];
	work_t              nxt   [NumStages];
	logic               adv;
	work_t              ent;

	// whole pipe moves unless output is full and not taken
	assign adv = !vld_s[NumStages] || out_ch.ready;
	assign in_ch.ready = adv;

	// operand alignment: dividend placed so that 64 steps yield the quotient
	always_comb begin
		logic [1:0]  sz;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] dv;
		sz = in_ch.data.size_sel;
		lo = in_ch.data.dividend_low;
		hi = in_ch.data.dividend_high;
		dv = in_ch.data.divisor;
		ent.q = '0;
		ent.st = ST_OK;
		case (opsize_t'(sz))
			SZ_BYTE: begin
				ent.d = {56'd0, dv[7:0]};
				ent.r = '0;
				ent.n = {48'd0, lo[15:0]};
			end
			SZ_WORD: begin
				ent.d = {48'd0, dv[15:0]};
				ent.r = '0;
				ent.n = {32'd0, hi[15:0], lo[15:0]};
			end
			SZ_DWORD: begin
				ent.d = {32'd0, dv[31:0]};
				ent.r = '0;
				ent.n = {hi[31:0], lo[31:0]};
			end
			default: begin
				ent.d = dv;
				ent.r = hi;
				ent.n = lo;
			end
		endcase
		if (ent.d == '0) begin
			ent.st = ST_DIV_ZERO;
		end else begin
			case (opsize_t'(sz))
				SZ_BYTE:  if (lo[15:8] >= dv[7:0]) ent.st = ST_OVERFLOW;
				SZ_WORD:  if (hi[15:0] >= dv[15:0]) ent.st = ST_OVERFLOW;
				SZ_DWORD: if (hi[31:0] >= dv[31:0]) ent.st = ST_OVERFLOW;
				default:  if (hi >= dv) ent.st = ST_OVERFLOW;
			endcase
		end
		// faulted items divide harmlessly; keep r below d
		if (ent.st != ST_OK) begin
			ent.r = '0;
			ent.d = '1;
		end
	end

	for (genvar g = 0; g < NumStages; g++) begin : g_stage
		xud_div_stage u_stage (.w_in(wrk_s[g]), .w_out(nxt[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NumStages-1:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wrk_s[0] <= ent;
			for (int k = 0; k < NumStages; k++) begin
				wrk_s[k+1] <= nxt[k];
			end
		end
	end

	always_comb begin
		out_ch.valid = vld_s[NumStages];
		out_ch.data.status = wrk_s[NumStages].st;
		if (wrk_s[NumStages].st == ST_OK) begin
			out_ch.data.quotient = wrk_s[NumStages].q;
			out_ch.data.remainder = wrk_s[NumStages].r;
		end else begin
			out_ch.data.quotient = '0;
			out_ch.data.remainder = '0;
		end
	end

	`XUD_ASSERT_IMP(a_ready_when_empty, !vld_s[NumStages], in_ch.ready)
	`XUD_ASSERT_NXT(a_hold_on_stall, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data))
	`XUD_ASSERT_IMP(a_status_code, out_ch.valid, out_ch.data.status != 2'd3)
endmodule
